[src/aes_pkg.sv]
// AES-128 package: S-box, round constants, round functions, FSM state type.
// No dependencies.
package aes_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_DONE
    } state_t;

    localparam logic [2:0] CFG_KEY_HIGH   = 3'd0;
    localparam logic [2:0] CFG_KEY_LOW    = 3'd1;
    localparam logic [2:0] CFG_IV_HIGH    = 3'd2;
    localparam logic [2:0] CFG_IV_LOW     = 3'd3;
    localparam logic [2:0] CFG_CHAIN_MODE = 3'd4;

    localparam int NUM_ROUNDS = 10;

    typedef struct packed {
        logic load;      // load state with input xor key 0, start round count
        logic step;      // run one round
        logic restart;   // clear round count
    } dp_cmd_t;

    typedef struct packed {
        logic last;      // current round is the final one
    } dp_sts_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of the block sits at bits 127-8i.
    function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
        return s[127 - 8*i -: 8];
    endfunction

    // SubBytes, ShiftRows and, unless last, MixColumns.
    function automatic logic [127:0] round_fn(input logic [127:0] s, input logic last);
        logic [7:0]   t [16];
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                t[i + 4*c] = sbox(get_byte(s, i + 4*((c + i) % 4)));
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (last)
            begin
                o[127 - 32*c -: 32] = {a0, a1, a2, a3};
            end
            else
            begin
                o[127 - 32*c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                                       a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                                       a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                                       xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
            end
        end
        return o;
    endfunction

    function automatic logic [31:0] sub_rot(input logic [31:0] w);
        return {sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0]), sbox(w[31:24])};
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] i);
        logic [7:0] r;
        case (i)
            4'd0: r = 8'h01; 4'd1: r = 8'h02; 4'd2: r = 8'h04; 4'd3: r = 8'h08;
            4'd4: r = 8'h10; 4'd5: r = 8'h20; 4'd6: r = 8'h40; 4'd7: r = 8'h80;
            4'd8: r = 8'h1b; 4'd9: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Next round key from the current one.
    function automatic logic [127:0] next_key(input logic [127:0] k, input logic [3:0] ri);
        logic [31:0] w0, w1, w2, w3;
        w0 = k[127:96] ^ sub_rot(k[31:0]) ^ {rcon(ri), 24'h0};
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

[src/aes_stream_if.sv]
// Valid/ready stream interface with a 129/128-bit payload.
// No dependencies.
interface aes_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic        restart;
    modport source (output valid, plain_high, plain_low, restart, input ready);
    modport sink   (input valid, plain_high, plain_low, restart, output ready);
endinterface

interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    modport source (output valid, cipher_high, cipher_low, input ready);
    modport sink   (input valid, cipher_high, cipher_low, output ready);
endinterface

[src/aes_ctrl.sv]
// AES round sequencer FSM.
// Depends on aes_pkg.
module aes_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  aes_pkg::dp_sts_t sts,
    output aes_pkg::dp_cmd_t cmd
);
    aes_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aes_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            aes_pkg::ST_IDLE:  if (in_valid) state_next = aes_pkg::ST_ROUND;
            aes_pkg::ST_ROUND: if (sts.last) state_next = aes_pkg::ST_DONE;
            aes_pkg::ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = in_valid ? aes_pkg::ST_ROUND : aes_pkg::ST_IDLE;
                end
            end
            default: state_next = aes_pkg::ST_IDLE;
        endcase
    end

    // A new request is taken as the finished result leaves.
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            aes_pkg::ST_IDLE:  in_ready = 1'b1;
            aes_pkg::ST_ROUND: in_ready = 1'b0;
            aes_pkg::ST_DONE:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
            end
            default: in_ready = 1'b0;
        endcase
        cmd.load    = in_ready && in_valid;
        cmd.step    = (state_reg == aes_pkg::ST_ROUND);
        cmd.restart = 1'b0;
    end
endmodule

[src/aes_datapath.sv]
// AES-128 datapath: config regs, on-the-fly key schedule, round unit, chaining.
// Depends on aes_pkg.
module aes_datapath
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [63:0]      cfg_data,
    input  logic [63:0]      plain_high,
    input  logic [63:0]      plain_low,
    input  logic             restart,
    input  aes_pkg::dp_cmd_t cmd,
    output aes_pkg::dp_sts_t sts,
    output logic [127:0]     cipher
);
    logic [127:0] key_reg, iv_reg, chain_reg, chain_next;
    logic         mode_reg;
    logic [127:0] state_reg, rkey_reg, plain_reg, text_reg;
    logic [3:0]   round_reg;
    logic [127:0] chain_use, blk_in, nk, rs;
    logic         last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            iv_reg   <= '0;
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                aes_pkg::CFG_KEY_HIGH:   key_reg[127:64] <= cfg_data;
                aes_pkg::CFG_KEY_LOW:    key_reg[63:0]   <= cfg_data;
                aes_pkg::CFG_IV_HIGH:    iv_reg[127:64]  <= cfg_data;
                aes_pkg::CFG_IV_LOW:     iv_reg[63:0]    <= cfg_data;
                aes_pkg::CFG_CHAIN_MODE: mode_reg        <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign chain_use = restart ? iv_reg : chain_reg;
    assign blk_in    = mode_reg ? chain_use : (chain_use ^ {plain_high, plain_low});
    assign last      = (round_reg == 4'(aes_pkg::NUM_ROUNDS - 1));
    assign nk        = aes_pkg::next_key(rkey_reg, round_reg);
    assign rs        = aes_pkg::round_fn(state_reg, last) ^ nk;
    assign sts.last  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg <= '0;
        end
        else if (cmd.load || cmd.restart)
        begin
            round_reg <= '0;
        end
        else if (cmd.step)
        begin
            round_reg <= last ? round_reg : round_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            state_reg <= blk_in ^ key_reg;
            rkey_reg  <= key_reg;
            plain_reg <= {plain_high, plain_low};
        end
        else if (cmd.step)
        begin
            state_reg <= rs;
            rkey_reg  <= nk;
            if (last)
            begin
                text_reg <= mode_reg ? (rs ^ plain_reg) : rs;
            end
        end
    end

    // Chain update: at accept CTR increments and CBC keeps the chain in use; CBC takes the ciphertext at the end.
    always_comb
    begin
        chain_next = chain_reg;
        if (cmd.load)
        begin
            chain_next = mode_reg ? (chain_use + 128'd1) : chain_use;
        end
        else if (cmd.step && last && !mode_reg)
        begin
            chain_next = rs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    assign cipher = text_reg;
endmodule

[src/aes128_block_encrypt.sv]
// AES-128 CBC/CTR block encryptor, top level.
// Each request runs one round per cycle in the shared round unit, key schedule computed
// alongside; no new request is taken while the rounds run.
// The next request is taken as the result leaves.
// Reset: asynchronous active-low clears config, chain and control; no clearing pass.
module aes128_block_encrypt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    aes_in_if.sink      in_ch,
    aes_out_if.source   out_ch
);
    aes_pkg::dp_cmd_t cmd;
    aes_pkg::dp_sts_t sts;
    logic [127:0]     cipher;

    // Sequencer: idle, ten rounds, hold result.
    aes_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Round unit and chaining registers.
    aes_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .plain_high (in_ch.plain_high),
        .plain_low  (in_ch.plain_low),
        .restart    (in_ch.restart),
        .cmd        (cmd),
        .sts        (sts),
        .cipher     (cipher)
    );

    assign out_ch.cipher_high = cipher[127:64];
    assign out_ch.cipher_low  = cipher[63:0];
endmodule

[src/aes_checker.sv]
// Port-level checker for aes128_block_encrypt, bound to the top level.
// Depends on aes_stream_if.
module aes_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [63:0] cipher_high
);
    // A request is never taken while a result is held but not leaving.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready) else $error("overrun");
    // Held result stays valid, with its high half stable.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(cipher_high)))
        else $error("result dropped");
    // After accept, no result until the rounds are done.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid [*10]) else $error("early result");
    // No accept at the start of the rounds.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("double accept");
endmodule

bind aes128_block_encrypt aes_checker u_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .cipher_high (out_ch.cipher_high)
);

[tb/sv/aes_enc_checker.sv]
// Checker for the AES-128 CBC/CTR encryptor: mirrors config writes, predicts
// ciphertext per accepted request and compares in order.
// Depends on aes_pkg and the stream interfaces.
`timescale 1ns / 100ps
module aes_enc_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    aes_in_if.sink      in_mon,
    aes_out_if.sink     out_mon,
    output int          fail_count,
    output int          pending
);
    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    localparam logic [7:0] RCON [10] = '{8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,
                                         8'h1b,8'h36};

    logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
    logic         ctr_mode;
    logic [127:0] round_keys [11];
    logic [127:0] chain_val;
    logic [127:0] cipher_q [$];

    function automatic logic [7:0] gmul2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    task automatic expand_keys();
        logic [31:0] w [44];
        logic [31:0] t;
        w[0] = key_hi[63:32]; w[1] = key_hi[31:0];
        w[2] = key_lo[63:32]; w[3] = key_lo[31:0];
        for (int i = 4; i < 44; i++)
        begin
            t = w[i-1];
            if (i % 4 == 0)
                t = sbox_word({t[23:0], t[31:24]}) ^ {RCON[i/4-1], 24'h0};
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r < 11; r++)
            round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endtask

    function automatic logic [127:0] aes_encrypt(input logic [127:0] blk);
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3;
        logic [127:0] o;
        blk = blk ^ round_keys[0];
        for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[i+4*c] = SBOX[s[i + 4*((c+i)%4)]];
            for (int c = 0; c < 4; c++)
            begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                if (r == 10)
                begin
                    s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
                end
                else
                begin
                    s[4*c]   = gmul2(a0) ^ gmul2(a1) ^ a1 ^ a2 ^ a3;
                    s[4*c+1] = a0 ^ gmul2(a1) ^ gmul2(a2) ^ a2 ^ a3;
                    s[4*c+2] = a0 ^ a1 ^ gmul2(a2) ^ gmul2(a3) ^ a3;
                    s[4*c+3] = gmul2(a0) ^ a0 ^ a1 ^ a2 ^ gmul2(a3);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = s[i] ^ round_keys[r][127-8*i -: 8];
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
        return o;
    endfunction

    assign pending = cipher_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [127:0] ks, ct, got;
        if (!rst_n)
        begin
            key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
            ctr_mode = 1'b0; chain_val = '0; fail_count = 0;
            cipher_q.delete();
            for (int r = 0; r < 11; r++) round_keys[r] = '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    aes_pkg::CFG_KEY_HIGH:
                    begin
                        key_hi = cfg_data;
                        expand_keys();
                    end
                    aes_pkg::CFG_KEY_LOW:
                    begin
                        key_lo = cfg_data;
                        expand_keys();
                    end
                    aes_pkg::CFG_IV_HIGH:    iv_hi = cfg_data;
                    aes_pkg::CFG_IV_LOW:     iv_lo = cfg_data;
                    aes_pkg::CFG_CHAIN_MODE: ctr_mode = cfg_data[0];
                    default:                 ;
                endcase
            end
            if (out_mon.valid && out_mon.ready)
            begin
                got = {out_mon.cipher_high, out_mon.cipher_low};
                if (cipher_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    ct = cipher_q.pop_front();
                    if (got[127:64] !== ct[127:64])
                    begin
                        $display("%0t: cipher_high exp %h got %h", $time, ct[127:64],
                                 got[127:64]);
                        fail_count++;
                    end
                    if (got[63:0] !== ct[63:0])
                    begin
                        $display("%0t: cipher_low exp %h got %h", $time, ct[63:0],
                                 got[63:0]);
                        fail_count++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                if (in_mon.restart) chain_val = {iv_hi, iv_lo};
                if (!ctr_mode)
                begin
                    ct = aes_encrypt({in_mon.plain_high, in_mon.plain_low} ^ chain_val);
                    chain_val = ct;
                end
                else
                begin
                    ks = aes_encrypt(chain_val);
                    ct = {in_mon.plain_high, in_mon.plain_low} ^ ks;
                    chain_val = chain_val + 128'd1;
                end
                cipher_q.push_back(ct);
            end
        end
    end
endmodule

[tb/sv/tb_top.sv]
// Top of the AES-128 encryptor testbench: clock, reset, config writes and
// request stimulus; verdict from aes_enc_checker. Depends on aes_pkg, interfaces, the DUT.
`timescale 1ns / 100ps
module tb_top;
    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    int          fail_count;
    int          pending;
    int          src_idle_pct;   // chance per cycle that the sender holds off
    int          snk_stall_pct;  // chance per cycle that the receiver stalls

    aes_in_if  in_ch ();
    aes_out_if out_ch ();

    aes128_block_encrypt u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    aes_enc_checker u_chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: ready re-drawn at each falling edge.
    always @(negedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // One config register write, one cycle wide, then cfg_we drops; block must be idle.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid, drain every outstanding result, then let the round unit settle.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (14) @(negedge clk);
    endtask

    task automatic set_config(input logic [127:0] key, input logic [127:0] iv,
                              input logic ctr);
        wait_idle();
        write_reg(aes_pkg::CFG_KEY_HIGH, key[127:64]);
        write_reg(aes_pkg::CFG_KEY_LOW, key[63:0]);
        write_reg(aes_pkg::CFG_IV_HIGH, iv[127:64]);
        write_reg(aes_pkg::CFG_IV_LOW, iv[63:0]);
        write_reg(aes_pkg::CFG_CHAIN_MODE, {63'd0, ctr});
    endtask

    // Send one request; valid stays high after the accept so that the next
    // request follows back to back when no idle is drawn.
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic rs);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.plain_high <= hi;
        in_ch.plain_low  <= lo;
        in_ch.restart    <= rs;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(5))
            0: v = '0;
            1: v = '1;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic logic [127:0] rand128();
        return {rand64(), rand64()};
    endfunction

    initial
    begin
        int rec_len;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_ch.valid = 1'b0; in_ch.plain_high = '0; in_ch.plain_low = '0;
        in_ch.restart = 1'b0;
        out_ch.ready = 1'b0;
        src_idle_pct = 0; snk_stall_pct = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Known-answer key, CBC; first block without restart uses zero chain.
        set_config(128'h000102030405060708090a0b0c0d0e0f, 128'h0, 1'b0);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
        send_block('0, '0, 1'b0);
        send_block('1, '1, 1'b1);
        send_block(64'h8000000000000000, 64'h1, 1'b0);
        // Restart without an IV write after it.
        set_config('1, 128'hffffffffffffffff_fffffffffffffffe, 1'b0);
        send_block('0, '1, 1'b1);
        send_block('1, '0, 1'b0);
        // Counter mode across a 128-bit wrap, then a low-half carry.
        set_config('0, 128'hffffffffffffffff_fffffffffffffffe, 1'b1);
        for (int i = 0; i < 4; i++) send_block(rand64(), rand64(), i == 0);
        wait_idle();
        write_reg(aes_pkg::CFG_IV_HIGH, 64'h0123456789abcdef);
        write_reg(aes_pkg::CFG_IV_LOW, '1);
        send_block('1, '1, 1'b1);
        send_block('0, '0, 1'b0);
        // Mode switch inside a record: chain carries over.
        wait_idle();
        write_reg(aes_pkg::CFG_CHAIN_MODE, 64'd0);
        send_block(rand64(), rand64(), 1'b0);
        send_block(rand64(), rand64(), 1'b0);
        wait_idle();
        write_reg(aes_pkg::CFG_CHAIN_MODE, 64'd1);
        send_block(rand64(), rand64(), 1'b0);
        // Unused index ignored.
        wait_idle();
        write_reg(3'd7, '1);
        write_reg(3'd5, '1);
        send_block(rand64(), rand64(), 1'b0);

        // Random records over the idling phases; each phase new settings.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    src_idle_pct = 0;  snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 52; snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;  snk_stall_pct = 52;
                end
                default:
                begin
                    src_idle_pct = 17; snk_stall_pct = 17;
                end
            endcase
            set_config(rand128(), (ph == 5) ? 128'hffffffffffffffff_fffffffffffffff0
                       : rand128(), ph[0]);
            for (int n = 0; n < 210; n += rec_len)
            begin
                rec_len = $urandom_range(1, 12);
                for (int k = 0; k < rec_len; k++)
                    send_block(rand64(), rand64(), (k == 0) && ($urandom_range(9) != 0));
                // After the first record, the sender holds off until the block has fully drained.
                if (n == 0) wait_idle();
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule

[sim.f]
src/aes_pkg.sv
src/aes_stream_if.sv
src/aes_ctrl.sv
src/aes_datapath.sv
src/aes128_block_encrypt.sv
src/aes_checker.sv
tb/sv/aes_enc_checker.sv
tb/sv/tb_top.sv
